@@ src/bbp_pkg.sv @@
// ----------------------------------------------------------------------------
// bbp_pkg: shared types and constants of the bimodal branch predictor
// Table geometry, counter encoding, queue item and back-end state codes.
// ----------------------------------------------------------------------------
package bbp_pkg;

  // Table size; index is taken as the low address bits, so keep it a power of two.
  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned CNT_W         = 2;
  localparam int unsigned STAT_W        = 32;
  localparam int unsigned PADDR_W       = 3;
  localparam int unsigned PDATA_W       = 32;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ADDR_W-1:0] FALL_THROUGH_STEP = ADDR_W'(4);

  localparam logic [CNT_W-1:0] CNT_MIN           = '0;
  localparam logic [CNT_W-1:0] CNT_MAX           = '1;
  localparam logic [CNT_W-1:0] INITIAL_STATE_RST = CNT_W'(1);

  // Register word index (paddr bits above the byte offset).
  localparam logic [PADDR_W-3:0] REG_INITIAL_STATE = '0;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             taken;
  } bbp_item_t;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] cnt;
  } bbp_entry_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_COMMIT
  } bbp_back_state_e;

endpackage

@@ src/bbp_cfg.sv @@
// ----------------------------------------------------------------------------
// bbp_cfg: configuration register file
// APB-style port holding the initial counter state for first-use entries.
// ----------------------------------------------------------------------------
module bbp_cfg import bbp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [CNT_W-1:0]   initial_state_o
);

  logic [CNT_W-1:0] init_q, init_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_INITIAL_STATE);

  always_comb begin
    init_d = init_q;
    if (wr_en) begin
      init_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= INITIAL_STATE_RST;
    end else begin
      init_q <= init_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_INITIAL_STATE) begin
      prdata = PDATA_W'(init_q);
    end
  end

  assign initial_state_o = init_q;

endmodule

@@ src/bbp_front.sv @@
// ----------------------------------------------------------------------------
// bbp_front: intake and classification
// Resolve the branch outcome, form the table index and buffer the item.
// ----------------------------------------------------------------------------
module bbp_front import bbp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              enable_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ADDR_W-1:0] branch_address_i,
  input  logic [ADDR_W-1:0] next_address_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output bbp_item_t         q_item_o
);

  bbp_item_t               slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0]       cnt_q, cnt_d;
  logic                    push, pop;
  bbp_item_t               item;

  // Not taken exactly when execution fell through to the next word.
  assign item.taken = next_address_i != (branch_address_i + FALL_THROUGH_STEP);
  assign item.idx   = branch_address_i[IDX_W-1:0];

  assign in_ready_o = enable_i && (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = cnt_q != '0;
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = rptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= item;
    end
  end

endmodule

@@ src/bbp_back.sv @@
// ----------------------------------------------------------------------------
// bbp_back: counter table and statistics
// Clear the table after reset, then read, update and report one item at a time.
// ----------------------------------------------------------------------------
module bbp_back import bbp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CNT_W-1:0]  initial_state_i,
  output logic              ready_o,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  bbp_item_t         q_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              predicted_taken_o,
  output logic              actual_taken_o,
  output logic              mispredicted_o,
  output logic [STAT_W-1:0] taken_total_o,
  output logic [STAT_W-1:0] not_taken_total_o,
  output logic [STAT_W-1:0] correct_total_o,
  output logic [STAT_W-1:0] miss_total_o
);

  bbp_entry_t        mem [TABLE_ENTRIES];
  bbp_entry_t        rdata_q;
  bbp_item_t         cur_q;
  bbp_back_state_e   state_q, state_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  bbp_entry_t        mem_wdata;
  logic              rd_en;
  logic              commit;
  logic              slot_free;
  logic [CNT_W-1:0]  cnt_now, cnt_next;
  logic              pred, miss;

  logic              out_valid_q, out_valid_d;
  logic              pred_q, taken_q, miss_q;
  logic [STAT_W-1:0] taken_cnt_q, not_taken_cnt_q, correct_cnt_q, miss_cnt_q;

  assign slot_free = !out_valid_q || out_ready_i;

  // A never-used entry takes its state from the register.
  assign cnt_now = rdata_q.valid ? rdata_q.cnt : initial_state_i;
  assign pred    = cnt_now[CNT_W-1];
  assign miss    = pred ^ cur_q.taken;

  always_comb begin
    cnt_next = cnt_now;
    if (cur_q.taken) begin
      if (cnt_now != CNT_MAX) begin
        cnt_next = cnt_now + 1'b1;
      end
    end else if (cnt_now != CNT_MIN) begin
      cnt_next = cnt_now - 1'b1;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    mem_we    = 1'b0;
    mem_waddr = cur_q.idx;
    mem_wdata = '{valid: 1'b1, cnt: cnt_next};
    rd_en     = 1'b0;
    commit    = 1'b0;
    q_ready_o = 1'b0;
    unique case (state_q)
      BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          rd_en   = 1'b1;
          state_d = BK_COMMIT;
        end
      end
      BK_COMMIT: begin
        // Hold until the output register can take the result.
        if (slot_free) begin
          commit  = 1'b1;
          mem_we  = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign ready_o = state_q != BK_CLEAR;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[q_item_i.idx];
      cur_q   <= q_item_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q     <= 1'b0;
      taken_cnt_q     <= '0;
      not_taken_cnt_q <= '0;
      correct_cnt_q   <= '0;
      miss_cnt_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (commit) begin
        if (cur_q.taken) begin
          taken_cnt_q <= taken_cnt_q + 1'b1;
        end else begin
          not_taken_cnt_q <= not_taken_cnt_q + 1'b1;
        end
        if (miss) begin
          miss_cnt_q <= miss_cnt_q + 1'b1;
        end else begin
          correct_cnt_q <= correct_cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      pred_q  <= pred;
      taken_q <= cur_q.taken;
      miss_q  <= miss;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign predicted_taken_o = pred_q;
  assign actual_taken_o    = taken_q;
  assign mispredicted_o    = miss_q;
  // Totals change only at a commit, which waits for the slot to free.
  assign taken_total_o     = taken_cnt_q;
  assign not_taken_total_o = not_taken_cnt_q;
  assign correct_total_o   = correct_cnt_q;
  assign miss_total_o      = miss_cnt_q;

endmodule

@@ src/bimodal_branch_predictor_top.sv @@
// ----------------------------------------------------------------------------
// bimodal_branch_predictor_top: bimodal branch predictor
// Two-bit saturating counters indexed by branch address, with running totals.
// ----------------------------------------------------------------------------
// Each item is one resolved branch (branch address and the address executed
// after it). The low address bits pick a 2-bit counter; its upper bit is the
// prediction, the counter then steps toward the outcome and saturates. A branch
// is not taken exactly when the next address is the branch address plus 4.
// An entry used for the first time starts from the initial_state register.
// After reset the block runs a clearing pass over the table, one entry a cycle,
// and accepts no item until it ends; register writes are taken throughout. In
// steady state the back end handles one item at a time: a registered table read
// (BK_IDLE), then the update and table write (BK_COMMIT), which waits for the
// result register to free; it takes no new item until that write is done. A
// two-item queue sits between intake and the table, and a result register lets
// the next item proceed while a result waits to be taken. Write registers only
// while idle.
// ----------------------------------------------------------------------------
module bimodal_branch_predictor_top import bbp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ADDR_W-1:0]  branch_address_i,
  input  logic [ADDR_W-1:0]  next_address_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               predicted_taken_o,
  output logic               actual_taken_o,
  output logic               mispredicted_o,
  output logic [STAT_W-1:0]  taken_total_o,
  output logic [STAT_W-1:0]  not_taken_total_o,
  output logic [STAT_W-1:0]  correct_total_o,
  output logic [STAT_W-1:0]  miss_total_o
);

  logic [CNT_W-1:0] initial_state;
  logic             back_ready;
  logic             q_valid, q_ready;
  bbp_item_t        q_item;

  bbp_cfg u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .initial_state_o (initial_state)
  );

  // Intake: hold off items until the clearing pass is done.
  bbp_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .enable_i         (back_ready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .branch_address_i (branch_address_i),
    .next_address_i   (next_address_i),
    .q_valid_o        (q_valid),
    .q_ready_i        (q_ready),
    .q_item_o         (q_item)
  );

  bbp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .initial_state_i   (initial_state),
    .ready_o           (back_ready),
    .q_valid_i         (q_valid),
    .q_ready_o         (q_ready),
    .q_item_i          (q_item),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .predicted_taken_o (predicted_taken_o),
    .actual_taken_o    (actual_taken_o),
    .mispredicted_o    (mispredicted_o),
    .taken_total_o     (taken_total_o),
    .not_taken_total_o (not_taken_total_o),
    .correct_total_o   (correct_total_o),
    .miss_total_o      (miss_total_o)
  );

endmodule
